FILE: sv/bbp_pkg.sv
// Shared types and constants for the balanced bin partitioner.
// Used by every module of the block; depends on nothing.
package bbp_pkg;

	localparam int MAX_ITEMS = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int WEIGHT_W  = 32;
	localparam int TOTAL_W   = 37;
	localparam int NB_W      = 6;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int Q_CNT_W   = 3;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// register index, taken from paddr[2]
	localparam logic REG_NUM_BINS = 1'b0;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                last_item;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   bin_index;
		logic [IDX_W-1:0]   item_index;
		logic [TOTAL_W-1:0] bin_total;
		logic               last_result;
		logic               overflow;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [IDX_W-1:0]    slot;
		logic                store;
		logic                last;
		logic [CNT_W-1:0]    count;
		logic [CNT_W-1:0]    bin_cnt;
		logic                dropped;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

	typedef enum logic [3:0] {
		S_LOAD,
		R_LDI,
		R_CAPI,
		R_SCAN,
		R_WR,
		P_ORD,
		P_WGT,
		P_WCAP,
		P_SRCH,
		P_ADD
	} back_state_t;

endpackage

FILE: sv/balanced_bin_partitioner.sv
// Top level of the balanced bin partitioner: config register, front, queue, back.
// Depends on bbp_pkg, bbp_front, bbp_queue, bbp_back.
//
// Weights load one item per cycle while the back end is loading, through a
// four-entry queue into a 32-entry weight store; the item marked last closes
// the job. The back end then ranks the n held items (one stored weight compared
// per cycle over the single read port), pairs smallest with largest round-robin
// while more than 2*bins+1 remain, and places the rest largest first into the
// lowest-numbered least-loaded bin. A greedy item scans the bin totals, one bin
// total scanned per cycle, before it is placed into its bin. Up to four items of
// the next job are taken while a job is worked; then full stays high until
// the back end returns to loading. Results wait in an output register.
module balanced_bin_partitioner (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  bbp_pkg::in_item_t          in_item,
	output logic                       empty,
	input  logic                       pop,
	output bbp_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bbp_pkg::ADDR_W-1:0] paddr,
	input  logic [bbp_pkg::DATA_W-1:0] pwdata,
	output logic [bbp_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	logic [bbp_pkg::NB_W-1:0] num_bins_q;
	logic                     q_push;
	bbp_pkg::q_entry_t        q_wr;
	bbp_pkg::q_entry_t        q_rd;
	bbp_pkg::q_stat_t         q_stat;
	bbp_pkg::back_stat_t      b_stat;

	assign pready = 1'b1;
	assign full   = q_stat.full;

	// config register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == bbp_pkg::REG_NUM_BINS)) begin
			num_bins_q <= pwdata[bbp_pkg::NB_W-1:0];
		end
	end

	// config register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == bbp_pkg::REG_NUM_BINS) begin
			prdata = bbp_pkg::DATA_W'(num_bins_q);
		end
	end

	bbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (in_item),
		.num_bins (num_bins_q),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_entry  (q_wr)
	);

	bbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.pop      (b_stat.pop),
		.rd_entry (q_rd),
		.stat     (q_stat)
	);

	bbp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_entry (q_rd),
		.q_stat  (q_stat),
		.pop     (pop),
		.empty   (empty),
		.result  (result),
		.stat    (b_stat)
	);

	// a non-final result only shows while the back end is still placing
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last_result) |-> b_stat.busy)
		else $error("non-final result while back end idle");

	// a waiting result holds still until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before it was taken");

	// the back end takes no queued item while placing
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.busy |-> !b_stat.pop)
		else $error("queue popped during placement");

endmodule

FILE: sv/bbp_queue.sv
// Short queue of classified items between front and back.
// Depends on bbp_pkg.
module bbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bbp_pkg::q_entry_t wr_entry,
	input  logic             pop,
	output bbp_pkg::q_entry_t rd_entry,
	output bbp_pkg::q_stat_t stat
);

	bbp_pkg::q_entry_t                 mem_q [bbp_pkg::Q_DEPTH];
	logic [bbp_pkg::Q_PTR_W-1:0]       wr_ptr_q;
	logic [bbp_pkg::Q_PTR_W-1:0]       rd_ptr_q;
	logic [bbp_pkg::Q_CNT_W-1:0]       cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign stat.full  = (cnt_q == bbp_pkg::Q_CNT_W'(bbp_pkg::Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_entry   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/bbp_front.sv
// Front end: accepts items, assigns store slots, flags drops, marks job end.
// Depends on bbp_pkg.
module bbp_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  bbp_pkg::in_item_t        in_item,
	input  logic [bbp_pkg::NB_W-1:0] num_bins,
	input  bbp_pkg::q_stat_t         q_stat,
	output logic                     q_push,
	output bbp_pkg::q_entry_t        q_entry
);

	logic [bbp_pkg::CNT_W-1:0] count_q;
	logic                      drop_q;
	logic                      accept;
	logic                      room;
	logic [bbp_pkg::CNT_W-1:0] count_n;
	logic [bbp_pkg::CNT_W-1:0] bin_cnt;

	assign accept = push && !q_stat.full;
	assign room   = (count_q < bbp_pkg::CNT_W'(bbp_pkg::MAX_ITEMS));

	// count including this item
	assign count_n = room ? count_q + 1'b1 : count_q;

	// bin count for the job: zero means one bin per item, clamp to store size
	always_comb begin
		if (num_bins == '0) begin
			bin_cnt = count_n;
		end else if (num_bins > bbp_pkg::NB_W'(bbp_pkg::MAX_ITEMS)) begin
			bin_cnt = bbp_pkg::CNT_W'(bbp_pkg::MAX_ITEMS);
		end else begin
			bin_cnt = bbp_pkg::CNT_W'(num_bins);
		end
	end

	// classified item
	always_comb begin
		q_entry.weight  = in_item.weight;
		q_entry.slot    = count_q[bbp_pkg::IDX_W-1:0];
		q_entry.store   = room;
		q_entry.last    = in_item.last_item;
		q_entry.count   = count_n;
		q_entry.bin_cnt = bin_cnt;
		q_entry.dropped = drop_q || !room;
		q_push          = accept && (room || in_item.last_item);
	end

	// item count and drop flag, cleared at job end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			if (in_item.last_item) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				count_q <= count_n;
				drop_q  <= drop_q || !room;
			end
		end
	end

endmodule

FILE: sv/bbp_back.sv
// Back end: stores weights, ranks them, places items into bins, holds result.
// Depends on bbp_pkg.
module bbp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bbp_pkg::q_entry_t   q_entry,
	input  bbp_pkg::q_stat_t    q_stat,
	input  logic                pop,
	output logic                empty,
	output bbp_pkg::result_t    result,
	output bbp_pkg::back_stat_t stat
);

	localparam int IW = bbp_pkg::IDX_W;
	localparam int CW = bbp_pkg::CNT_W;
	localparam int TW = bbp_pkg::TOTAL_W;
	localparam int WW = bbp_pkg::WEIGHT_W;
	localparam int NI = bbp_pkg::MAX_ITEMS;

	bbp_pkg::back_state_t state_q, state_d;

	// memories
	logic [WW-1:0] weight_mem [NI];
	logic [IW-1:0] order_mem  [NI];
	logic [WW-1:0] weight_rd_q;
	logic [IW-1:0] order_rd_q;
	logic [IW-1:0] weight_raddr;
	logic [IW-1:0] order_raddr;
	logic          weight_we;
	logic [IW-1:0] weight_waddr;
	logic          order_we;

	// bin totals with per-bin valid bits, cleared each job
	logic [TW-1:0] bt_q [NI];
	logic [NI-1:0] bt_vld_q;
	logic [IW-1:0] bt_ridx;
	logic [TW-1:0] bt_rd;

	// job and sequencing registers
	logic [CW-1:0] n_q;
	logic [CW-1:0] bins_q;
	logic          drop_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [IW-1:0] j_s1;
	logic          cmp_vld_s1;
	logic [IW-1:0] rank_q;
	logic [WW-1:0] wi_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] left_q;
	logic [IW-1:0] rr_q;
	logic          half_q;
	logic          pair_q;
	logic [IW-1:0] item_q;
	logic [WW-1:0] w_q;
	logic [IW-1:0] bin_q;
	logic [TW-1:0] best_q;
	logic [IW-1:0] b_q;

	// output register
	logic             out_vld_q;
	bbp_pkg::result_t out_q;

	logic          out_free;
	logic          q_pop;
	logic          pair_now;
	logic [CW-1:0] hi_pos;
	logic [IW-1:0] pos;
	logic          less;
	logic          take;
	logic [TW-1:0] sum;
	logic          emit;
	logic          scan_done;

	assign out_free = !out_vld_q || pop;
	assign empty    = !out_vld_q;
	assign result   = out_q;

	// pair step while more than 2*bins+1 items are left
	assign pair_now = half_q || ({1'b0, left_q} > {bins_q, 1'b1});
	assign hi_pos   = lo_q + left_q - 1'b1;
	assign pos      = (pair_now && !half_q) ? lo_q[IW-1:0] : hi_pos[IW-1:0];

	// stable rank compare: lower weight, or equal weight at lower index
	assign less = (weight_rd_q < wi_q) || ((weight_rd_q == wi_q) && (j_s1 < i_q[IW-1:0]));

	assign bt_ridx = (state_q == bbp_pkg::P_SRCH) ? b_q : bin_q;
	assign bt_rd   = bt_vld_q[bt_ridx] ? bt_q[bt_ridx] : '0;
	assign take    = (b_q == '0) || (bt_rd < best_q);
	assign sum     = bt_rd + TW'(w_q);
	assign scan_done = (j_q == n_q) && !cmp_vld_s1;

	assign stat.busy = (state_q != bbp_pkg::S_LOAD);
	assign stat.pop  = q_pop;

	// next state and memory controls
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		weight_we    = 1'b0;
		weight_waddr = q_entry.slot;
		order_we     = 1'b0;
		weight_raddr = i_q[IW-1:0];
		order_raddr  = pos;
		emit         = 1'b0;
		unique case (state_q)
			bbp_pkg::S_LOAD: begin
				if (!q_stat.empty) begin
					q_pop     = 1'b1;
					weight_we = q_entry.store;
					if (q_entry.last && (q_entry.count != '0)) begin
						state_d = bbp_pkg::R_LDI;
					end
				end
			end
			bbp_pkg::R_LDI: begin
				state_d = bbp_pkg::R_CAPI;
			end
			bbp_pkg::R_CAPI: begin
				state_d = bbp_pkg::R_SCAN;
			end
			bbp_pkg::R_SCAN: begin
				weight_raddr = j_q[IW-1:0];
				if (scan_done) begin
					state_d = bbp_pkg::R_WR;
				end
			end
			bbp_pkg::R_WR: begin
				order_we = 1'b1;
				if (i_q == n_q - 1'b1) begin
					state_d = bbp_pkg::P_ORD;
				end else begin
					state_d = bbp_pkg::R_LDI;
				end
			end
			bbp_pkg::P_ORD: begin
				state_d = bbp_pkg::P_WGT;
			end
			bbp_pkg::P_WGT: begin
				weight_raddr = order_rd_q;
				state_d      = bbp_pkg::P_WCAP;
			end
			bbp_pkg::P_WCAP: begin
				state_d = pair_q ? bbp_pkg::P_ADD : bbp_pkg::P_SRCH;
			end
			bbp_pkg::P_SRCH: begin
				if ({1'b0, b_q} == bins_q - 1'b1) begin
					state_d = bbp_pkg::P_ADD;
				end
			end
			bbp_pkg::P_ADD: begin
				if (out_free) begin
					emit = 1'b1;
					if (!pair_q && (left_q == CW'(1))) begin
						state_d = bbp_pkg::S_LOAD;
					end else begin
						state_d = bbp_pkg::P_ORD;
					end
				end
			end
			default: begin
				state_d = bbp_pkg::S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbp_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// weight and order stores, registered reads
	always_ff @(posedge clk) begin
		if (weight_we) begin
			weight_mem[weight_waddr] <= q_entry.weight;
		end
		weight_rd_q <= weight_mem[weight_raddr];
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[rank_q] <= i_q[IW-1:0];
		end
		order_rd_q <= order_mem[order_raddr];
	end

	// bin total storage
	always_ff @(posedge clk) begin
		if (emit) begin
			bt_q[bin_q] <= sum;
		end
	end

	// control: job setup, valid bits, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt_vld_q   <= '0;
			out_vld_q  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			if (q_pop && q_entry.last) begin
				bt_vld_q <= '0;
			end else if (emit) begin
				bt_vld_q[bin_q] <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			cmp_vld_s1 <= (state_q == bbp_pkg::R_SCAN) && (j_q < n_q);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bbp_pkg::S_LOAD: begin
				if (q_pop && q_entry.last) begin
					n_q    <= q_entry.count;
					bins_q <= q_entry.bin_cnt;
					drop_q <= q_entry.dropped;
					i_q    <= '0;
					lo_q   <= '0;
					left_q <= q_entry.count;
					rr_q   <= '0;
					half_q <= 1'b0;
				end
			end
			bbp_pkg::R_LDI: begin
				j_q <= '0;
			end
			bbp_pkg::R_CAPI: begin
				wi_q   <= weight_rd_q;
				rank_q <= '0;
			end
			bbp_pkg::R_SCAN: begin
				if (j_q < n_q) begin
					j_q  <= j_q + 1'b1;
					j_s1 <= j_q[IW-1:0];
				end
				if (cmp_vld_s1 && less) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			bbp_pkg::R_WR: begin
				i_q <= i_q + 1'b1;
			end
			bbp_pkg::P_ORD: begin
				pair_q <= pair_now;
			end
			bbp_pkg::P_WGT: begin
				item_q <= order_rd_q;
			end
			bbp_pkg::P_WCAP: begin
				w_q   <= weight_rd_q;
				bin_q <= rr_q;
				b_q   <= '0;
			end
			bbp_pkg::P_SRCH: begin
				if (take) begin
					bin_q  <= b_q;
					best_q <= bt_rd;
				end
				b_q <= b_q + 1'b1;
			end
			bbp_pkg::P_ADD: begin
				if (emit) begin
					out_q.bin_index   <= bin_q;
					out_q.item_index  <= item_q;
					out_q.bin_total   <= sum;
					out_q.last_result <= !pair_q && (left_q == CW'(1));
					out_q.overflow    <= drop_q;
					if (pair_q && !half_q) begin
						half_q <= 1'b1;
					end else if (pair_q) begin
						half_q <= 1'b0;
						lo_q   <= lo_q + 1'b1;
						left_q <= left_q - CW'(2);
						if ({1'b0, rr_q} == bins_q - 1'b1) begin
							rr_q <= '0;
						end else begin
							rr_q <= rr_q + 1'b1;
						end
					end else begin
						left_q <= left_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
